@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the sample decoder.
// Uses the clk and arst_n signals of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds on a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ rtl/gsdd_pkg.sv @@
// Types, register indexes, format codes and decode tables of the sample decoder.
// Has no dependencies.
package gsdd_pkg;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 8;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [2:0] fmt_t;
	typedef logic signed [2:0] smp_t;

	localparam cfg_index_t REG_DECIMATION = 1'b0;
	localparam cfg_index_t REG_SAMPLE_FORMAT = 1'b1;

	localparam fmt_t FMT_ONE_BIT = 3'd0;
	localparam fmt_t FMT_TWO_BIT = 3'd1;
	localparam fmt_t FMT_IQ_1_1 = 3'd2;
	localparam fmt_t FMT_IQ_2_2 = 3'd3;
	localparam fmt_t FMT_PACK = 3'd4;

	localparam smp_t SMP_POS1 = 3'sd1;
	localparam smp_t SMP_NEG1 = -3'sd1;
	localparam smp_t SMP_POS3 = 3'sd3;
	localparam smp_t SMP_NEG3 = -3'sd3;

	localparam smp_t TWO_BIT_LUT [4] = '{SMP_POS1, SMP_NEG1, SMP_POS3, SMP_NEG3};

	function automatic smp_t mag_sign(input logic sgn, input logic mag);
		smp_t v;
		v = mag ? SMP_POS3 : SMP_POS1;
		return sgn ? smp_t'(-v) : v;
	endfunction

endpackage

@@ rtl/gsdd_byte_if.sv @@
// Valid/ready channel that carries one raw sampler byte per transaction.
// Has no dependencies.
interface gsdd_byte_if;
	logic valid;
	logic ready;
	logic [7:0] raw_byte;

	modport source (output valid, output raw_byte, input ready);
	modport sink (input valid, input raw_byte, output ready);
endinterface

@@ rtl/gsdd_result_if.sv @@
// Valid/ready channel that carries one decoded result per transaction.
// Depends on gsdd_pkg for the sample type.
interface gsdd_result_if;
	logic valid;
	logic ready;
	gsdd_pkg::smp_t sample;
	logic [7:0] packed_byte;
	logic component;
	logic last;

	modport source (output valid, output sample, output packed_byte, output component,
		output last, input ready);
	modport sink (input valid, input sample, input packed_byte, input component,
		input last, output ready);
endinterface

@@ rtl/gnss_sample_decimating_decoder.sv @@
// Decimates a stream of sampler bytes and decodes the kept bytes into signed samples.
// Decodes through a decode stage and a result register. A kept byte in an I/Q format holds
// the decode stage for an I and a Q transaction, so the next byte waits until its Q result
// is loaded; all other bytes run at one per cycle while the result register is not stalled.
// Each byte is registered in the decode stage before its result enters the result register.
// Depends on gsdd_pkg, gsdd_byte_if, gsdd_result_if and assert_macros.svh.
`include "assert_macros.svh"

module gnss_sample_decimating_decoder #(
	parameter int PHASE_WIDTH = 8
) (
	input logic clk,
	input logic arst_n,
	gsdd_byte_if.sink in_ch,
	gsdd_result_if.source out_ch,
	input logic cfg_wr_en,
	input gsdd_pkg::cfg_index_t cfg_index,
	input gsdd_pkg::cfg_data_t cfg_data
);
	import gsdd_pkg::*;

	logic [7:0] decimation_q;
	fmt_t sample_format_q;
	logic [PHASE_WIDTH-1:0] phase_q;
	logic [5:0] pack_accum_q;
	logic [1:0] pack_count_q;

	logic valid_s1;
	logic half_s1;
	fmt_t fmt_s1;
	logic [7:0] byte_s1;
	logic [7:0] packed_s1;

	logic out_valid_q;
	smp_t out_sample_q;
	logic [7:0] out_packed_q;
	logic out_comp_q;
	logic out_last_q;

	logic accept;
	logic keep;
	logic pack_done;
	logic produces;
	logic out_load;
	logic s1_last;
	logic [7:0] dec_m1;
	logic [PHASE_WIDTH+7:0] reload_wide;
	logic [7:0] pack_word;
	logic [5:0] pack_next;
	smp_t dec_sample;
	logic [7:0] dec_packed;
	logic dec_comp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decimation_q <= 8'd1;
			sample_format_q <= FMT_ONE_BIT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DECIMATION: decimation_q <= cfg_data;
				REG_SAMPLE_FORMAT: sample_format_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign s1_last = !((fmt_s1 == FMT_IQ_1_1 || fmt_s1 == FMT_IQ_2_2) && !half_s1);
	assign out_load = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || (out_load && s1_last);
	assign accept = in_ch.valid && in_ch.ready;

	assign keep = (phase_q == '0);
	assign dec_m1 = (decimation_q == 8'd0) ? 8'd0 : decimation_q - 8'd1;
	assign reload_wide = {{PHASE_WIDTH{1'b0}}, dec_m1};
	assign pack_done = (pack_count_q == 2'd3);
	assign pack_word = {in_ch.raw_byte[1:0], pack_accum_q};
	assign produces = keep && (sample_format_q == FMT_ONE_BIT
		|| sample_format_q == FMT_TWO_BIT || sample_format_q == FMT_IQ_1_1
		|| sample_format_q == FMT_IQ_2_2 || (sample_format_q == FMT_PACK && pack_done));

	always_comb begin
		pack_next = pack_accum_q;
		case (pack_count_q)
			2'd0: pack_next[1:0] = in_ch.raw_byte[1:0];
			2'd1: pack_next[3:2] = in_ch.raw_byte[1:0];
			2'd2: pack_next[5:4] = in_ch.raw_byte[1:0];
			default: pack_next = 6'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			pack_accum_q <= 6'd0;
			pack_count_q <= 2'd0;
		end else if (accept) begin
			if (!keep) begin
				phase_q <= phase_q - PHASE_WIDTH'(1);
			end else begin
				phase_q <= reload_wide[PHASE_WIDTH-1:0];
				if (sample_format_q == FMT_PACK) begin
					pack_accum_q <= pack_next;
					pack_count_q <= pack_count_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			half_s1 <= 1'b0;
		end else if (accept && produces) begin
			valid_s1 <= 1'b1;
			half_s1 <= 1'b0;
		end else if (out_load && s1_last) begin
			valid_s1 <= 1'b0;
			half_s1 <= 1'b0;
		end else if (out_load) begin
			half_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && produces) begin
			fmt_s1 <= sample_format_q;
			byte_s1 <= in_ch.raw_byte;
			packed_s1 <= pack_word;
		end
	end

	always_comb begin
		dec_sample = '0;
		dec_packed = 8'd0;
		dec_comp = 1'b0;
		case (fmt_s1)
			FMT_ONE_BIT: dec_sample = byte_s1[0] ? SMP_NEG1 : SMP_POS1;
			FMT_TWO_BIT: dec_sample = TWO_BIT_LUT[byte_s1[1:0]];
			FMT_IQ_1_1: begin
				dec_sample = (half_s1 ? byte_s1[1] : byte_s1[0]) ? SMP_NEG1 : SMP_POS1;
				dec_comp = half_s1;
			end
			FMT_IQ_2_2: begin
				dec_sample = half_s1 ? mag_sign(byte_s1[1], byte_s1[3])
					: mag_sign(byte_s1[0], byte_s1[2]);
				dec_comp = half_s1;
			end
			FMT_PACK: dec_packed = packed_s1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q <= dec_sample;
			out_packed_q <= dec_packed;
			out_comp_q <= dec_comp;
			out_last_q <= s1_last;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.sample = out_sample_q;
	assign out_ch.packed_byte = out_packed_q;
	assign out_ch.component = out_comp_q;
	assign out_ch.last = out_last_q;

	`ASSERT_NEVER(a_half_only_iq, valid_s1 && half_s1 && fmt_s1 != FMT_IQ_1_1 && fmt_s1 != FMT_IQ_2_2, "Q half pending for a format without a Q sample")
	`ASSERT_CLK(a_q_follows_i, (out_load && !s1_last) |=> (valid_s1 && half_s1), "I result was not followed by a pending Q result")
	`ASSERT_CLK(a_pack_state_hold, !accept |=> $stable(pack_count_q) && $stable(pack_accum_q), "Pack state changed without an accepted byte")

endmodule

@@ verif/tb_gnss_sample_decimating_decoder.sv @@
// Self-checking regression for the decimating GNSS sample decoder.
// Depends on gsdd_pkg, gsdd_byte_if, gsdd_result_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_gnss_sample_decimating_decoder;
	import gsdd_pkg::*;

	localparam int PHASE_W = 8;
	localparam int SETTLE_CYCLES = 10;
	localparam int LIMIT_CYCLES = 400000;
	localparam fmt_t FMT_RSVD_5 = 3'd5;
	localparam fmt_t FMT_RSVD_7 = 3'd7;

	typedef struct {
		smp_t sample;
		logic [7:0] packed_byte;
		logic component;
		logic last;
	} decoded_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	cfg_index_t cfg_index;
	cfg_data_t cfg_data;

	gsdd_byte_if byte_ch ();
	gsdd_result_if res_ch ();

	gnss_sample_decimating_decoder #(
		.PHASE_WIDTH(PHASE_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(byte_ch),
		.out_ch(res_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	decoded_t pending_samples[$];
	logic [PHASE_W-1:0] skip_left;
	logic [5:0] pack_bits;
	logic [1:0] pack_cnt;
	logic [7:0] decim_ratio;
	fmt_t fmt_sel;
	int sent_cnt;
	int mismatch_cnt;
	int src_idle_pct;
	int snk_idle_pct;
	int cycle_cnt;

	always #5 clk = ~clk;

	function automatic smp_t sm_level(input logic sgn, input logic mag);
		smp_t lvl;
		lvl = mag ? SMP_POS3 : SMP_POS1;
		if (sgn)
			lvl = mag ? SMP_NEG3 : SMP_NEG1;
		return lvl;
	endfunction

	function automatic void push_sample(input smp_t s, input logic comp, input logic lst);
		decoded_t r;
		r.sample = s;
		r.packed_byte = 8'h00;
		r.component = comp;
		r.last = lst;
		pending_samples.push_back(r);
	endfunction

	function automatic void decode_byte(input logic [7:0] b);
		logic [7:0] ratio;
		decoded_t r;
		ratio = (decim_ratio == 8'd0) ? 8'd1 : decim_ratio;
		if (skip_left != '0) begin
			skip_left = skip_left - PHASE_W'(1);
			return;
		end
		skip_left = PHASE_W'(ratio - 8'd1);
		case (fmt_sel)
		FMT_ONE_BIT: push_sample(sm_level(b[0], 1'b0), 1'b0, 1'b1);
		FMT_TWO_BIT: push_sample(sm_level(b[0], b[1]), 1'b0, 1'b1);
		FMT_IQ_1_1: begin
			push_sample(sm_level(b[0], 1'b0), 1'b0, 1'b0);
			push_sample(sm_level(b[1], 1'b0), 1'b1, 1'b1);
		end
		FMT_IQ_2_2: begin
			push_sample(sm_level(b[0], b[2]), 1'b0, 1'b0);
			push_sample(sm_level(b[1], b[3]), 1'b1, 1'b1);
		end
		FMT_PACK: begin
			if (pack_cnt == 2'd3) begin
				r.sample = '0;
				r.packed_byte = {b[1:0], pack_bits};
				r.component = 1'b0;
				r.last = 1'b1;
				pending_samples.push_back(r);
				pack_bits = '0;
				pack_cnt = '0;
			end else begin
				pack_bits = pack_bits | (6'(b[1:0]) << (2 * pack_cnt));
				pack_cnt = pack_cnt + 2'd1;
			end
		end
		default: ;
		endcase
	endfunction

	// Called right after a falling edge; returns right after a falling edge.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.raw_byte <= b;
		do
			@(posedge clk);
		while (!byte_ch.ready);
		decode_byte(b);
		sent_cnt++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		byte_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_samples.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input cfg_index_t idx, input cfg_data_t data);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == REG_DECIMATION)
			decim_ratio = data;
		else
			fmt_sel = fmt_t'(data[2:0]);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_decode_formats();
		send_byte(8'h00);
		send_byte(8'hFF);
		cfg_write(REG_SAMPLE_FORMAT, cfg_data_t'(FMT_TWO_BIT));
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'hFF);
		cfg_write(REG_SAMPLE_FORMAT, cfg_data_t'(FMT_IQ_1_1));
		send_byte(8'h01);
		send_byte(8'h02);
		cfg_write(REG_SAMPLE_FORMAT, cfg_data_t'(FMT_IQ_2_2));
		send_byte(8'h05);
		send_byte(8'h0A);
		cfg_write(REG_SAMPLE_FORMAT, cfg_data_t'(FMT_PACK));
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'hFF);
	endtask

	task automatic test_special_cases();
		cfg_write(REG_DECIMATION, 8'd0);
		cfg_write(REG_SAMPLE_FORMAT, cfg_data_t'(FMT_ONE_BIT));
		send_byte(8'hFE);
		send_byte(8'h01);
		cfg_write(REG_SAMPLE_FORMAT, cfg_data_t'(FMT_RSVD_5));
		send_byte(8'h03);
		cfg_write(REG_SAMPLE_FORMAT, cfg_data_t'(FMT_RSVD_7));
		send_byte(8'hFF);
		// A partial pack must survive a detour through another format.
		cfg_write(REG_SAMPLE_FORMAT, cfg_data_t'(FMT_PACK));
		send_byte(8'h03);
		send_byte(8'h02);
		cfg_write(REG_SAMPLE_FORMAT, 8'hF8 | cfg_data_t'(FMT_TWO_BIT));
		send_byte(8'h03);
		cfg_write(REG_SAMPLE_FORMAT, cfg_data_t'(FMT_PACK));
		send_byte(8'h01);
		send_byte(8'h00);
		// The long skip left by the largest ratio carries into the next test.
		cfg_write(REG_DECIMATION, 8'd255);
		send_byte(8'h00);
		send_byte(8'h00);
	endtask

	task automatic test_random_traffic(input int src_pct, input int snk_pct, input int budget);
		int start_sent;
		int seg_len;
		int pick;
		logic [7:0] ratio;
		logic [2:0] fmt_val;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		start_sent = sent_cnt;
		while (sent_cnt - start_sent < budget) begin
			pick = $urandom_range(99);
			if (pick < 45)
				ratio = 8'd1;
			else if (pick < 75)
				ratio = 8'($urandom_range(2, 4));
			else if (pick < 85)
				ratio = 8'd0;
			else if (pick < 95)
				ratio = 8'($urandom_range(5, 40));
			else
				ratio = 8'($urandom_range(200, 255));
			cfg_write(REG_DECIMATION, ratio);
			fmt_val = ($urandom_range(99) < 90) ? 3'($urandom_range(0, 4))
				: 3'($urandom_range(5, 7));
			cfg_write(REG_SAMPLE_FORMAT,
				{($urandom_range(1) == 1) ? 5'($urandom) : 5'd0, fmt_val});
			seg_len = (ratio <= 8'd4) ? $urandom_range(16, 64)
				: 2 * ratio + $urandom_range(1, 8);
			if (seg_len > budget - (sent_cnt - start_sent))
				seg_len = budget - (sent_cnt - start_sent);
			repeat (seg_len) send_byte(8'($urandom));
		end
	endtask

	always @(negedge clk)
		res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_samples.size() == 0) begin
				$error("result transaction with none expected: sample %0d packed_byte 0x%02h",
					res_ch.sample, res_ch.packed_byte);
				mismatch_cnt++;
			end else begin
				want = pending_samples.pop_front();
				if (res_ch.sample !== want.sample) begin
					$error("sample: expected %0d, got %0d", want.sample, res_ch.sample);
					mismatch_cnt++;
				end
				if (res_ch.packed_byte !== want.packed_byte) begin
					$error("packed_byte: expected 0x%02h, got 0x%02h", want.packed_byte,
						res_ch.packed_byte);
					mismatch_cnt++;
				end
				if (res_ch.component !== want.component) begin
					$error("component: expected %0b, got %0b", want.component,
						res_ch.component);
					mismatch_cnt++;
				end
				if (res_ch.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, res_ch.last);
					mismatch_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("gnss_sample_decimating_decoder regression: fail");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_DECIMATION;
		cfg_data = '0;
		byte_ch.valid = 1'b0;
		byte_ch.raw_byte = 8'h00;
		res_ch.ready = 1'b0;
		skip_left = '0;
		pack_bits = '0;
		pack_cnt = '0;
		decim_ratio = 8'd1;
		fmt_sel = FMT_ONE_BIT;
		sent_cnt = 0;
		mismatch_cnt = 0;
		cycle_cnt = 0;
		src_idle_pct = 6;
		snk_idle_pct = 57;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_decode_formats();
		test_special_cases();
		test_random_traffic(6, 57, 420);
		test_random_traffic(57, 6, 420);
		test_random_traffic(0, 0, 420);

		wait_idle();
		if (mismatch_cnt == 0)
			$display("gnss_sample_decimating_decoder regression: pass");
		else
			$display("gnss_sample_decimating_decoder regression: fail");
		$finish;
	end

endmodule
